// ===== sv/vt_pkg.sv =====
// ----------------------------------------------------------------------------
// vt_pkg: shared types for the 4x4 vertex transform
// Command codes, beat layouts and the lane control bundle.
// ----------------------------------------------------------------------------
package vt_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_AFFINE = 2'd1,
        CMD_FULL   = 2'd2,
        CMD_DIR    = 2'd3
    } t_cmd;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word [3:0]              t_vec4;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_cmd        command;
        logic [3:0]  element_index;
        t_word       element_value;
        t_word       in_x;
        t_word       in_y;
        t_word       in_z;
        t_word       in_w;
    } t_in_beat;

    typedef struct packed {
        t_word out_x;
        t_word out_y;
        t_word out_z;
        t_word out_w;
        logic  saturated;
    } t_out_beat;

    // Control for one lane: stage enables and the command entering the multipliers.
    typedef struct packed {
        logic en_mul;
        logic en_sum;
        t_cmd cmd;
    } t_lane_ctl;

endpackage

// ===== sv/vertex_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_4x4: homogeneous 4x4 matrix-vector transform, Q16.16
// Keeps a 4x4 fixed-point matrix and transforms one vector per cycle while o_in_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries commands.
//   A load beat writes one matrix element (row*4+column) at acceptance and
//   yields no output beat. Affine, full and direction beats each yield one
//   output beat on o_out_valid / i_out_stall / o_out_beat.
//   Pipeline: three register stages (products, row sums, output register).
//   Throughput: one beat per cycle while o_in_stall is low, set by four
//   parallel lanes of four 32x32 multipliers each, one lane per matrix row.
//   A transform uses the matrix as it stands when the beat is accepted, so a
//   load right behind a transform does not affect that transform.
//   Reset (i_rst_n low, synchronous) empties the pipeline and reloads the
//   identity matrix (diagonal 1 << FRAC_BITS).
//   Receiver stall: the output beat holds; each stage still advances into a
//   bubble ahead of it, so o_in_stall rises only once all three stages hold
//   a transform.
//   Each row is the exact sum of its products, shifted right by FRAC_BITS
//   (floor) and clamped to 32 bits; a clamp on any returned row sets
//   saturated.
// ----------------------------------------------------------------------------
module vertex_transform_4x4
    import vt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam t_word ONE = t_word'(1) <<< FRAC_BITS;

    // Matrix store, row-major; each element feeds a fixed lane input.
    t_word      r_mat [16];

    // Pipeline occupancy and the command that travels with each stage.
    logic       r_v1, r_v2, r_out_valid;
    t_cmd       r_cmd1, r_cmd2, r_out_cmd;
    logic       en1, en2, en3;
    logic       accept;
    logic       n_v1;

    t_vec4      vec_in;
    t_vec4      lane_res;
    logic [3:0] lane_sat;
    t_lane_ctl  lane_ctl;
    t_out_beat  merged;
    t_out_beat  r_out_beat;

    // Advance a stage when the one after it is empty or moving on.
    assign en3        = !r_out_valid || !i_out_stall;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;
    assign accept     = i_in_valid && en1;
    assign n_v1       = accept && (i_in_beat.command != CMD_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= n_v1;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_out_valid <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cmd1 <= i_in_beat.command;
        end
        if (en2) begin
            r_cmd2 <= r_cmd1;
        end
        if (en3) begin
            r_out_cmd  <= r_cmd2;
            r_out_beat <= merged;
        end
    end

    // Load writes one element; reset restores identity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (accept && i_in_beat.command == CMD_LOAD) begin
            r_mat[i_in_beat.element_index] <= i_in_beat.element_value;
        end
    end

    assign vec_in[0] = i_in_beat.in_x;
    assign vec_in[1] = i_in_beat.in_y;
    assign vec_in[2] = i_in_beat.in_z;
    assign vec_in[3] = i_in_beat.in_w;

    always_comb begin
        lane_ctl.en_mul = en1;
        lane_ctl.en_sum = en2;
        lane_ctl.cmd    = i_in_beat.command;
    end

    for (genvar r = 0; r < 4; r++) begin : g_lane
        t_vec4 row;
        always_comb begin
            for (int c = 0; c < 4; c++) begin
                row[c] = r_mat[r*4 + c];
            end
        end

        vt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_row    (row),
            .i_vec    (vec_in),
            .o_result (lane_res[r]),
            .o_sat    (lane_sat[r])
        );
    end

    vt_merge u_merge (
        .i_cmd    (r_cmd2),
        .i_result (lane_res),
        .i_sat    (lane_sat),
        .o_beat   (merged)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // w is only returned in full mode.
    a_w_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (r_out_cmd != CMD_FULL) |-> o_out_beat.out_w == '0)
        else $error("out_w nonzero outside full mode");

    // A clamp flag means some returned row sits at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.saturated |->
            o_out_beat.out_x == WORD_MAX || o_out_beat.out_x == WORD_MIN ||
            o_out_beat.out_y == WORD_MAX || o_out_beat.out_y == WORD_MIN ||
            o_out_beat.out_z == WORD_MAX || o_out_beat.out_z == WORD_MIN ||
            o_out_beat.out_w == WORD_MAX || o_out_beat.out_w == WORD_MIN)
        else $error("saturated set without a clamped component");

    // A load beat never enters the transform pipeline.
    a_load_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_beat.command == CMD_LOAD) |=> !r_v1)
        else $error("load beat entered the pipeline");

    // Reset leaves the identity diagonal and an empty output.
    a_reset_ident: assert property (@(posedge i_clk)
        !i_rst_n |=> r_mat[0] == ONE && r_mat[15] == ONE && r_mat[1] == '0
                     && !o_out_valid)
        else $error("reset did not restore identity");

endmodule

// ===== sv/vt_lane.sv =====
// ----------------------------------------------------------------------------
// vt_lane: one matrix row times the input vector
// Stage one registers four products, stage two sums, shifts and clamps.
// ----------------------------------------------------------------------------
module vt_lane
    import vt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  t_lane_ctl i_ctl,
    input  t_vec4     i_row,
    input  t_vec4     i_vec,
    output t_word     o_result,
    output logic      o_sat
);

    localparam int SUM_W = 66;

    logic signed [63:0]      r_prod [4];
    logic signed [63:0]      n_prod [4];
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shifted;
    logic                    fits;
    t_word                   r_result;
    logic                    r_sat;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_prod[c] = 64'(i_vec[c]) * 64'(i_row[c]);
        end
        unique case (i_ctl.cmd)
            CMD_AFFINE: n_prod[3] = 64'(i_row[3]) <<< FRAC_BITS;
            CMD_FULL:   n_prod[3] = 64'(i_vec[3]) * 64'(i_row[3]);
            CMD_LOAD,
            CMD_DIR:    n_prod[3] = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            for (int c = 0; c < 4; c++) begin
                r_prod[c] <= n_prod[c];
            end
        end
    end

    // Exact sum, floor shift, then clamp to the signed word range.
    assign sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
               + SUM_W'(r_prod[3]);
    assign shifted = sum >>> FRAC_BITS;
    assign fits = (&shifted[SUM_W-1:WORD_W-1]) || !(|shifted[SUM_W-1:WORD_W-1]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sat <= !fits;
            if (fits) begin
                r_result <= shifted[WORD_W-1:0];
            end else if (shifted[SUM_W-1]) begin
                r_result <= WORD_MIN;
            end else begin
                r_result <= WORD_MAX;
            end
        end
    end

    assign o_result = r_result;
    assign o_sat    = r_sat;

endmodule

// ===== sv/vt_merge.sv =====
// ----------------------------------------------------------------------------
// vt_merge: combine the four lane results into one output beat
// Drop the w row outside full mode and fold the clamp flags.
// ----------------------------------------------------------------------------
module vt_merge
    import vt_pkg::*;
(
    input  t_cmd       i_cmd,
    input  t_vec4      i_result,
    input  logic [3:0] i_sat,
    output t_out_beat  o_beat
);

    logic full;

    assign full = (i_cmd == CMD_FULL);

    always_comb begin
        o_beat.out_x     = i_result[0];
        o_beat.out_y     = i_result[1];
        o_beat.out_z     = i_result[2];
        o_beat.out_w     = full ? i_result[3] : '0;
        o_beat.saturated = (|i_sat[2:0]) || (full && i_sat[3]);
    end

endmodule
